/* sv/float32_to_half_or_bfloat16_assert.svh */
// Assertion macros for the float32 to half or bfloat16 converter checks.
`ifndef FLOAT32_TO_HALF_OR_BFLOAT16_ASSERT_SVH
`define FLOAT32_TO_HALF_OR_BFLOAT16_ASSERT_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define F2HB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("f2hb check failed");

// Antecedent implies consequent in the next cycle, outside reset.
`define F2HB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("f2hb check failed");

// Next-cycle implication that is also checked while reset is applied.
`define F2HB_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("f2hb reset check failed");

`endif

/* sv/f2hb_pkg.sv */
// Shared types and constants for the float32 to half or bfloat16 converter.
package f2hb_pkg;

  localparam int DATA_W          = 32;
  localparam int OFFSET_W        = 18;
  localparam int FMT_W           = 2;
  localparam int INDEX_WIDTH_DEF = 16;

  typedef enum logic [FMT_W-1:0] {
    FMT_FP32 = 2'd0,
    FMT_FP16 = 2'd1,
    FMT_BF16 = 2'd2
  } fmt_t;

  localparam logic [15:0] HALF_INF    = 16'h7C00;
  localparam logic [15:0] HALF_QNAN   = 16'h7E00;
  localparam logic [7:0]  EXP_MAX     = 8'hFF;
  localparam logic [7:0]  EXP_OVF     = 8'd142;
  localparam logic [7:0]  EXP_TINY    = 8'd102;
  localparam logic [7:0]  EXP_NORM    = 8'd113;
  localparam logic [7:0]  EXP_SUB_SH  = 8'd126;
  localparam logic [7:0]  EXP_REBIAS  = 8'd112;
  localparam logic [31:0] BF16_RND    = 32'h0000_7FFF;

endpackage

/* sv/f2hb_in_if.sv */
// Input channel interface: fp32 bit pattern and element index.
interface f2hb_in_if #(
  parameter int INDEX_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [31:0]            in_bits;
  logic [INDEX_WIDTH-1:0] element_index;

  modport source (output valid, output in_bits, output element_index, input ready);
  modport sink   (input valid, input in_bits, input element_index, output ready);
endinterface

/* sv/f2hb_out_if.sv */
// Result channel interface: converted bit pattern and byte offset.
interface f2hb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_bits;
  logic [17:0] byte_offset;

  modport source (output valid, output out_bits, output byte_offset, input ready);
  modport sink   (input valid, input out_bits, input byte_offset, output ready);
endinterface

/* sv/f2hb_cfg_if.sv */
// Configuration write channel interface: output format register.
interface f2hb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/f2hb_conv.sv */
// Combinational fp32 to fp32/fp16/bf16 conversion and byte offset.
module f2hb_conv
  import f2hb_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic [DATA_W-1:0]      bits_i,
  input  logic [INDEX_WIDTH-1:0] idx_i,
  input  logic [FMT_W-1:0]       fmt_i,
  output logic [DATA_W-1:0]      res_o,
  output logic [OFFSET_W-1:0]    off_o
);

  localparam int EXT_W = OFFSET_W + INDEX_WIDTH + 2;

  logic        sign;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [15:0] half_res;
  logic [15:0] bf_res;
  logic [31:0] bf_sum;

  logic [7:0]  sh8;
  logic [4:0]  sh;
  logic [24:0] sub_v;
  logic [24:0] sub_base;
  logic [24:0] sub_mask;
  logic [24:0] sub_rem;
  logic [24:0] sub_half;
  logic        sub_rnd;
  logic [10:0] sub_val;

  logic [7:0]  hexp8;
  logic        norm_rnd;
  logic [14:0] norm_val;

  logic [EXT_W-1:0] off_x2;
  logic [EXT_W-1:0] off_x4;

  assign sign = bits_i[31];
  assign ex   = bits_i[30:23];
  assign man  = bits_i[22:0];

  always_comb begin
    sh8      = EXP_SUB_SH - ex;
    sh       = sh8[4:0];
    sub_v    = {1'b0, 1'b1, man};
    sub_base = sub_v >> sh;
    sub_mask = (25'd1 << sh) - 25'd1;
    sub_rem  = sub_v & sub_mask;
    sub_half = 25'd1 << (sh - 5'd1);
    sub_rnd  = (sub_rem > sub_half) || ((sub_rem == sub_half) && sub_base[0]);
    sub_val  = sub_base[10:0] + {10'd0, sub_rnd};
  end

  always_comb begin
    hexp8    = ex - EXP_REBIAS;
    norm_rnd = man[12] && ((man[11:0] != 12'd0) || man[13]);
    norm_val = {hexp8[4:0], man[22:13]} + {14'd0, norm_rnd};
  end

  always_comb begin
    priority if (ex == EXP_MAX) begin
      half_res = {sign, 15'd0} | ((man == 23'd0) ? HALF_INF : HALF_QNAN);
    end else if (ex == 8'd0) begin
      half_res = {sign, 15'd0};
    end else if (ex > EXP_OVF) begin
      half_res = {sign, 15'd0} | HALF_INF;
    end else if (ex < EXP_TINY) begin
      half_res = {sign, 15'd0};
    end else if (ex < EXP_NORM) begin
      half_res = {sign, 4'd0, sub_val};
    end else begin
      half_res = {sign, norm_val};
    end
  end

  assign bf_sum = bits_i + BF16_RND + {31'd0, bits_i[16]};
  assign bf_res = bf_sum[31:16];

  assign off_x2 = {{OFFSET_W + 1{1'b0}}, idx_i, 1'b0};
  assign off_x4 = {{OFFSET_W{1'b0}}, idx_i, 2'b00};

  always_comb begin
    unique case (fmt_i)
      FMT_FP32: begin
        res_o = bits_i;
        off_o = off_x4[OFFSET_W-1:0];
      end
      FMT_FP16: begin
        res_o = {16'd0, half_res};
        off_o = off_x2[OFFSET_W-1:0];
      end
      FMT_BF16: begin
        res_o = {16'd0, bf_res};
        off_o = off_x2[OFFSET_W-1:0];
      end
      default: begin
        res_o = '0;
        off_o = '0;
      end
    endcase
  end

endmodule

/* sv/float32_to_half_or_bfloat16.sv */
// Top level of the float32 to fp32/fp16/bf16 element converter.
// Accepts one item per clock while the sink takes results, and returns one
// result per item: the item lands in an input register, one pass of conversion
// logic runs, and the result lands in the output register, which holds while
// the sink stalls. Sustained rate is one item per cycle without stalls, set by
// the two registers; ready falls only when both hold items and the sink stalls.
// The format register resets to fp16, is always ready and must be written only
// while the block is idle.
module float32_to_half_or_bfloat16
  import f2hb_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  f2hb_in_if.sink   in_if,
  f2hb_out_if.source out_if,
  f2hb_cfg_if.sink  cfg_if
);

  logic [FMT_W-1:0]       fmt_r;
  logic                   s0_v_r;
  logic [DATA_W-1:0]      s0_bits_r;
  logic [INDEX_WIDTH-1:0] s0_idx_r;
  logic                   out_v_r;
  logic [DATA_W-1:0]      out_bits_r;
  logic [OFFSET_W-1:0]    out_off_r;

  logic [DATA_W-1:0]      res_nxt;
  logic [OFFSET_W-1:0]    off_nxt;
  logic                   out_adv;
  logic                   s0_adv;

  assign out_adv     = !out_v_r || out_if.ready;
  assign s0_adv      = !s0_v_r || out_adv;
  assign in_if.ready = s0_adv;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_v_r;
  assign out_if.out_bits    = out_bits_r;
  assign out_if.byte_offset = out_off_r;

  f2hb_conv #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_conv (
    .bits_i (s0_bits_r),
    .idx_i  (s0_idx_r),
    .fmt_i  (fmt_r),
    .res_o  (res_nxt),
    .off_o  (off_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_FP16;
      s0_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        fmt_r <= cfg_if.data;
      end
      if (s0_adv) begin
        s0_v_r <= in_if.valid;
      end
      if (out_adv) begin
        out_v_r <= s0_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && in_if.valid) begin
      s0_bits_r <= in_if.in_bits;
      s0_idx_r  <= in_if.element_index;
    end
    if (out_adv && s0_v_r) begin
      out_bits_r <= res_nxt;
      out_off_r  <= off_nxt;
    end
  end

endmodule

/* sv/f2hb_checker.sv */
// Port-level checks for the converter and their bind to the top level.
`include "float32_to_half_or_bfloat16_assert.svh"

module f2hb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_bits,
  input logic [17:0] byte_offset
);

  `F2HB_ASSERT_RST(a_reset_clears_out, clk, !rst_n, !out_valid)
  `F2HB_ASSERT_NOW(a_cfg_always_ready, clk, rst_n, cfg_valid, cfg_ready)
  `F2HB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bits) && $stable(byte_offset))
  `F2HB_ASSERT_NOW(a_wide_word_offset, clk, rst_n, out_valid && (out_bits[31:16] != 16'd0), byte_offset[1:0] == 2'd0)

endmodule

bind float32_to_half_or_bfloat16 f2hb_checker u_f2hb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .cfg_valid   (cfg_if.valid),
  .cfg_ready   (cfg_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_bits    (out_if.out_bits),
  .byte_offset (out_if.byte_offset)
);

/* sim/f2hb_convert_checker.sv */
// Checker for the float32 converter: predicts each converted item and compares results.
`timescale 1ns / 100ps

module f2hb_convert_checker
  import f2hb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [DATA_W-1:0]     in_bits,
  input  logic [15:0]           in_index,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DATA_W-1:0]     out_bits,
  input  logic [OFFSET_W-1:0]   out_offset,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [FMT_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [DATA_W-1:0]   bits;
    logic [OFFSET_W-1:0] offset;
  } conv_result_t;

  localparam logic [31:0] HALF_MAN_CARRY = 32'h400;
  localparam logic [31:0] HIDDEN_ONE     = 32'h80_0000;

  conv_result_t     expected_results[$];
  logic [FMT_W-1:0] active_fmt;

  function automatic logic [31:0] shift_round_even(logic [31:0] v, int unsigned sh);
    logic [31:0] kept;
    logic [31:0] rest;
    logic [31:0] halfway;
    if (sh == 0) return v;
    kept    = v >> sh;
    rest    = v & ((32'd1 << sh) - 32'd1);
    halfway = 32'd1 << (sh - 1);
    if (rest > halfway || (rest == halfway && kept[0])) kept = kept + 32'd1;
    return kept;
  endfunction

  function automatic logic [15:0] fp32_to_half(logic [31:0] x);
    logic [15:0] sgn;
    logic [7:0]  ex;
    logic [31:0] man;
    logic [31:0] m;
    int          e;
    int          hexp;
    sgn = {x[31], 15'd0};
    ex  = x[30:23];
    man = {9'd0, x[22:0]};
    if (ex == EXP_MAX) return sgn | ((man == 0) ? HALF_INF : HALF_QNAN);
    if (ex == 8'd0) return sgn;
    e = int'(ex) - 127;
    if (e > 15) return sgn | HALF_INF;
    if (e < -25) return sgn;
    if (e < -14) begin
      m = shift_round_even(man | HIDDEN_ONE, 13 + (-14 - e));
      return sgn | m[15:0];
    end
    hexp = e + 15;
    m    = shift_round_even(man, 13);
    if (m == HALF_MAN_CARRY) begin
      m    = 32'd0;
      hexp = hexp + 1;
      if (hexp >= 31) return sgn | HALF_INF;
    end
    return sgn | {1'b0, 5'(hexp), m[9:0]};
  endfunction

  function automatic logic [15:0] bf16_round_even(logic [31:0] x);
    logic [31:0] sum;
    sum = x + BF16_RND + {31'd0, x[16]};
    return sum[31:16];
  endfunction

  function automatic conv_result_t predict_conversion(logic [FMT_W-1:0] fmt,
                                                      logic [31:0] x, logic [15:0] idx);
    conv_result_t r;
    r = '0;
    case (fmt)
      FMT_FP32: begin
        r.bits   = x;
        r.offset = {idx, 2'b00};
      end
      FMT_FP16: begin
        r.bits   = {16'd0, fp32_to_half(x)};
        r.offset = {1'b0, idx, 1'b0};
      end
      FMT_BF16: begin
        r.bits   = {16'd0, bf16_round_even(x)};
        r.offset = {1'b0, idx, 1'b0};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    conv_result_t want;
    if (!rst_n) begin
      active_fmt = FMT_FP16;
      expected_results.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result bits %h offset %h", $time, out_bits, out_offset);
          mismatches = mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          outstanding = outstanding - 1;
          if (out_bits !== want.bits) begin
            $display("%0t: out_bits expected %h, got %h", $time, want.bits, out_bits);
            mismatches = mismatches + 1;
          end
          if (out_offset !== want.offset) begin
            $display("%0t: byte_offset expected %h, got %h", $time, want.offset, out_offset);
            mismatches = mismatches + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) active_fmt = cfg_data;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_conversion(active_fmt, in_bits, in_index));
        outstanding = outstanding + 1;
      end
    end
  end

endmodule

/* sim/float32_to_half_or_bfloat16_tb.sv */
// Testbench top for the float32 converter: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module float32_to_half_or_bfloat16_tb;
  import f2hb_pkg::*;

  localparam logic [FMT_W-1:0] FMT_UNUSED  = 2'd3;
  localparam int               CYCLE_LIMIT = 200000;
  localparam int               PHASES      = 8;
  localparam int               PHASE_ITEMS = 80;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_request;

  f2hb_in_if #(.INDEX_WIDTH(16)) in_ch ();
  f2hb_out_if                    out_ch ();
  f2hb_cfg_if                    cfg_ch ();

  float32_to_half_or_bfloat16 #(.INDEX_WIDTH(16)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  f2hb_convert_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_bits     (in_ch.in_bits),
    .in_index    (in_ch.element_index),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_bits    (out_ch.out_bits),
    .out_offset  (out_ch.byte_offset),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left    = 0;
    hold_request = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(logic [31:0] bits, logic [15:0] idx);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_bits       <= bits;
    in_ch.element_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_format(logic [FMT_W-1:0] fmt);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= fmt;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_fp32();
    logic [31:0] r;
    logic [12:0] low13;
    logic [15:0] low16;
    r = $urandom;
    case ($urandom_range(0, 3))
      0:       low13 = 13'h1000;
      1:       low13 = 13'h0FFF;
      2:       low13 = 13'h1001;
      default: low13 = 13'h0000;
    endcase
    case ($urandom_range(0, 2))
      0:       low16 = 16'h8000;
      1:       low16 = 16'h7FFF;
      default: low16 = 16'h8001;
    endcase
    case ($urandom_range(0, 7))
      1: r[30:23] = 8'($urandom_range(103, 142));
      2: begin
        r[30:23] = 8'($urandom_range(100, 113));
        if ($urandom_range(0, 1) == 1) r[12:0] = low13;
      end
      3: begin
        r[30:23] = 8'($urandom_range(103, 143));
        r[12:0]  = low13;
      end
      4: begin
        r[30:23] = ($urandom_range(0, 1) == 1) ? EXP_MAX : 8'd0;
        if ($urandom_range(0, 1) == 1) r[22:0] = 23'd0;
      end
      5: r[15:0] = low16;
      6: begin
        r[30:23] = 8'($urandom_range(100, 143));
        r[22:13] = 10'h3FF;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] random_index();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  initial begin
    logic [FMT_W-1:0] phase_fmt[PHASES];
    phase_fmt = '{FMT_FP16, FMT_FP32, FMT_BF16, FMT_FP16,
                  FMT_BF16, FMT_FP32, FMT_FP16, FMT_BF16};
    rst_n               = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    in_ch.valid         = 1'b0;
    in_ch.in_bits       = '0;
    in_ch.element_index = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(32'h0000_0000, 16'h0000);
    send_item(32'h8000_0000, 16'hFFFF);
    send_item(32'h7F80_0000, 16'h0001);
    send_item(32'hFF80_0000, 16'h8000);
    send_item(32'h7FC0_0001, 16'h1234);
    send_item(32'hFF80_0001, 16'h7FFF);
    send_item(32'h0000_0001, 16'h0002);
    send_item(32'h807F_FFFF, 16'h0003);
    send_item(32'h477F_E000, 16'h0004);
    send_item(32'h477F_F000, 16'h0005);
    send_item(32'h4780_0000, 16'h0006);
    send_item(32'h3300_0000, 16'h0007);
    send_item(32'h3300_0001, 16'h0008);
    send_item(32'h3280_0000, 16'h0009);
    send_item(32'h387F_FFFF, 16'h000A);
    send_item(32'h3F80_1000, 16'h000B);
    send_item(32'h3F80_3000, 16'h000C);
    send_item(32'h3FFF_F000, 16'h000D);
    write_format(FMT_FP32);
    send_item(32'hFFFF_FFFF, 16'hFFFF);
    send_item(32'h3F80_0000, 16'h0000);
    write_format(FMT_BF16);
    send_item(32'h7FFF_FFFF, 16'hFFFF);
    send_item(32'hFFFF_FFFF, 16'h0001);
    send_item(32'h3F80_8000, 16'h0002);
    send_item(32'h3F81_8000, 16'h0003);
    send_item(32'h7F7F_FFFF, 16'h0004);
    write_format(FMT_UNUSED);
    send_item(32'h3F80_0000, 16'hFFFF);
    send_item(32'hC000_0000, 16'h0010);

    for (int p = 0; p < PHASES; p++) begin
      write_format(phase_fmt[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 0 || p == 3) && i == 20) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          hold_request = 60;
          @(negedge clk);
        end
        if ((p == 1 || p == 6) && i == 40) drain_results();
        send_item(random_fp32(), random_index());
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
